### hw/rtl/clint_pkg.sv
// Shared types and constants for the core-local timer and interrupt block.
`default_nettype none

package clint_pkg;

  localparam int unsigned NUM_HARTS_DEFAULT = 4;

  // 15625/512 truncates to 30 microsecond ticks per time count increment.
  localparam logic [15:0] PRESCALE_RESET = 16'(15625 / 512);

  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam logic [15:0] TIME_BASE = 16'hBFF8;
  localparam logic [15:0] TIME_HI   = 16'hBFFC;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Per-hart strobes for one executed transaction.
  typedef struct packed {
    logic tick;
    logic sw_wr;
    logic cmp_wr;
    logic cmp_hi;
  } hart_ctl_t;

  typedef struct packed {
    logic [63:0] cmp;
    logic        timer_pend;
    logic        sw_pend;
  } hart_stat_t;

endpackage

`default_nettype wire

### hw/rtl/clint_hart.sv
// One hart's compare register, timer pending bit and software pending bit.
`default_nettype none

module clint_hart (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire clint_pkg::hart_ctl_t  ctl,
  input  wire logic [31:0]           wdata,
  input  wire logic [63:0]           time_now,
  input  wire logic [63:0]           time_tick,
  output clint_pkg::hart_stat_t      stat
);

  logic [63:0] cmp;
  logic        timer_pend;
  logic        sw_pend;
  logic [63:0] cmp_next;

  assign cmp_next = ctl.cmp_hi ? {wdata, cmp[31:0]} : {cmp[63:32], wdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp        <= '1;
      timer_pend <= 1'b0;
      sw_pend    <= 1'b0;
    end else begin
      if (ctl.cmp_wr) begin
        cmp        <= cmp_next;
        timer_pend <= (time_now >= cmp_next);
      end else if (ctl.tick && (time_tick >= cmp)) begin
        // a tick only ever sets the pending bit
        timer_pend <= 1'b1;
      end
      if (ctl.sw_wr) begin
        sw_pend <= wdata[0];
      end
    end
  end

  assign stat.cmp        = cmp;
  assign stat.timer_pend = timer_pend;
  assign stat.sw_pend    = sw_pend;

endmodule

`default_nettype wire

### hw/rtl/core_local_timer_interruptor.sv
// Top level of the core-local timer and interrupt block.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------------
//   in       | input     | in_valid / in_ready  | command, address, write_data
//   out      | output    | out_valid / out_ready| read_data, timer_irq, software_irq,
//            |           |                      | access_error
//   cfg      | input     | cfg_we (no wait)     | cfg_wdata (prescale divisor)
//
// A transaction accepted into the input register then runs a single pass of decode, 64-bit
// compares and state update into the result register, which offers the result; this waits
// while the result register holds an undrained result. One transaction per cycle is
// sustained while out_ready holds high; in_ready stays high while the result register is
// free or being drained. Stalls on out_ready back up into the input register. Reset is
// synchronous for valid, timer and hart state; the data registers are not reset.
`default_nettype none

module core_local_timer_interruptor #(
  parameter int unsigned NUM_HARTS = clint_pkg::NUM_HARTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic [3:0]       timer_irq,
  output logic [3:0]       software_irq,
  output logic             access_error,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
  localparam logic [16:0] SOFT_END = 17'(4 * NUM_HARTS);
  localparam logic [16:0] CMP_END  = 17'(16384 + 8 * NUM_HARTS);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [15:0] s1_addr;
  logic [31:0] s1_wdata;

  // timer state
  logic [15:0] divisor;
  logic [15:0] pcount;
  logic [63:0] time_count;
  logic [63:0] time_p1;      // always time_count + 1
  logic        bump;
  logic [63:0] time_tick;

  logic advance;
  logic exec;
  logic is_tick;
  logic is_read;
  logic is_write;
  logic aligned;
  logic sw_hit;
  logic cmp_hit;
  logic time_hit;
  logic [15:0] cmp_off;
  logic [HART_W-1:0] sw_idx;
  logic [HART_W-1:0] cmp_idx;
  logic [31:0] rdata_next;
  logic        err_next;

  clint_pkg::hart_ctl_t  ctl  [NUM_HARTS];
  clint_pkg::hart_stat_t stat [NUM_HARTS];

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign exec     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= command;
      s1_addr  <= address;
      s1_wdata <= write_data;
    end
  end

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (s1_cmd)
      clint_pkg::CMD_TICK:  is_tick  = exec;
      clint_pkg::CMD_READ:  is_read  = exec;
      clint_pkg::CMD_WRITE: is_write = exec;
      default: ;  // unused code: no effect
    endcase
  end

  // address decode
  assign aligned  = (s1_addr[1:0] == 2'b00);
  assign sw_hit   = aligned && ({1'b0, s1_addr} < SOFT_END);
  assign cmp_off  = s1_addr - clint_pkg::CMP_BASE;
  assign cmp_hit  = aligned && (s1_addr >= clint_pkg::CMP_BASE)
                    && ({1'b0, s1_addr} < CMP_END);
  assign time_hit = (s1_addr == clint_pkg::TIME_BASE) || (s1_addr == clint_pkg::TIME_HI);
  assign sw_idx   = s1_addr[HART_W+1:2];
  assign cmp_idx  = cmp_off[HART_W+2:3];

  // prescaler wraps when count+1 reaches the divisor; a zero divisor acts as one
  assign bump      = ({1'b0, pcount} + 17'd1) >= {1'b0, divisor};
  assign time_tick = bump ? time_p1 : time_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor    <= clint_pkg::PRESCALE_RESET;
      pcount     <= '0;
      time_count <= '0;
      time_p1    <= 64'd1;
    end else begin
      if (cfg_we) begin
        divisor <= cfg_wdata;
      end
      if (is_tick) begin
        if (bump) begin
          pcount     <= '0;
          time_count <= time_p1;
          time_p1    <= time_p1 + 64'd1;
        end else begin
          pcount <= pcount + 16'd1;
        end
      end
    end
  end

  for (genvar h = 0; h < NUM_HARTS; h++) begin : g_hart
    assign ctl[h].tick   = is_tick;
    assign ctl[h].sw_wr  = is_write && sw_hit && (sw_idx == HART_W'(h));
    assign ctl[h].cmp_wr = is_write && cmp_hit && (cmp_idx == HART_W'(h));
    assign ctl[h].cmp_hi = cmp_off[2];

    clint_hart u_hart (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[h]),
      .wdata     (s1_wdata),
      .time_now  (time_count),
      .time_tick (time_tick),
      .stat      (stat[h])
    );
  end

  always_comb begin
    rdata_next = '0;
    if (is_read) begin
      priority if (sw_hit) begin
        rdata_next = {31'd0, stat[sw_idx].sw_pend};
      end else if (cmp_hit) begin
        rdata_next = cmp_off[2] ? stat[cmp_idx].cmp[63:32] : stat[cmp_idx].cmp[31:0];
      end else if (time_hit) begin
        rdata_next = s1_addr[2] ? time_count[63:32] : time_count[31:0];
      end
    end
  end

  assign err_next = (is_read || is_write) && !(sw_hit || cmp_hit || time_hit);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      read_data    <= rdata_next;
      access_error <= err_next;
    end
  end

  // pending state only changes when a new result is loaded, so it matches the held result
  for (genvar i = 0; i < 4; i++) begin : g_irq
    if (i < NUM_HARTS) begin : g_on
      assign timer_irq[i]    = stat[i].timer_pend;
      assign software_irq[i] = stat[i].sw_pend;
    end else begin : g_off
      assign timer_irq[i]    = 1'b0;
      assign software_irq[i] = 1'b0;
    end
  end

  a_time_p1 : assert property (@(posedge clk) disable iff (rst)
    time_p1 == time_count + 64'd1)
    else $error("time_p1 out of step with time_count");

  a_err_no_data : assert property (@(posedge clk) disable iff (rst)
    out_valid && access_error |-> read_data == 32'd0)
    else $error("access error returned nonzero read data");

  a_time_only_tick : assert property (@(posedge clk) disable iff (rst)
    !is_tick |=> time_count == $past(time_count))
    else $error("time counter moved without a tick");

  a_ready_free : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
